>>> rtl/core/pf_pkg.sv
// shared types, constants and lookup functions for the playfair block
package pf_pkg;

    localparam int SIZE       = 5;
    localparam int LW         = 5;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 64;
    localparam int SQ_HALF_W  = 2 * SIZE * LW;
    localparam int SQ_ROW_W   = SIZE * LW;
    localparam int BURST_MAX  = 4;

    localparam logic [LW-1:0] LETTER_I     = 5'd8;
    localparam logic [LW-1:0] LETTER_J     = 5'd9;
    localparam logic [LW-1:0] FILLER_RESET = 5'd23;

    typedef logic [LW-1:0] t_letter;
    typedef logic [2:0]    t_pos;

    // cell (row, col) sits at bit 5*(5*row+col) of the flattened square
    typedef logic [SIZE-1:0][SIZE-1:0][LW-1:0] t_square;

    typedef enum logic [1:0] {
        REG_SQ01   = 2'd0,
        REG_SQ23   = 2'd1,
        REG_SQ4    = 2'd2,
        REG_FILLER = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        K_PAIR   = 2'd0,
        K_REPEAT = 2'd1,
        K_ODD    = 2'd2
    } t_kind;

    typedef struct packed {
        t_square square;
        t_letter filler;
    } t_cfg;

    typedef struct packed {
        t_kind   kind;
        t_letter a;
        t_letter b;
        logic    dec;
        logic    fin;
    } t_job;

    typedef struct packed {
        t_letter letter;
        logic    last;
        logic    bad;
    } t_beat;

    typedef struct packed {
        logic found;
        t_pos row;
        t_pos col;
    } t_loc;

    function automatic t_letter fold_j(input t_letter l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    // lowest-numbered matching cell wins
    function automatic t_loc locate(input t_square sq, input t_letter l);
        t_loc res;
        res = '0;
        for (int r = SIZE - 1; r >= 0; r--) begin
            for (int c = SIZE - 1; c >= 0; c--) begin
                if (sq[r][c] == l) begin
                    res.found = 1'b1;
                    res.row   = t_pos'(r);
                    res.col   = t_pos'(c);
                end
            end
        end
        return res;
    endfunction

    function automatic t_pos wrap_step(input t_pos v, input logic dec);
        t_pos res;
        if (dec) begin
            res = (v == '0) ? t_pos'(SIZE - 1) : v - t_pos'(1);
        end else begin
            res = (v == t_pos'(SIZE - 1)) ? '0 : v + t_pos'(1);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/pf_regs.sv
// configuration register file: square cells and filler letter
module pf_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pf_pkg::ADDR_W-1:0] paddr,
    input  logic [pf_pkg::DATA_W-1:0] pwdata,
    output logic [pf_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output pf_pkg::t_cfg              o_cfg
);

    logic [pf_pkg::SQ_HALF_W-1:0] r_sq01;
    logic [pf_pkg::SQ_HALF_W-1:0] r_sq23;
    logic [pf_pkg::SQ_ROW_W-1:0]  r_sq4;
    pf_pkg::t_letter              r_filler;
    logic                         wr_en;
    pf_pkg::t_reg                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = pf_pkg::t_reg'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq01   <= '0;
            r_sq23   <= '0;
            r_sq4    <= '0;
            r_filler <= pf_pkg::FILLER_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                pf_pkg::REG_SQ01:   r_sq01   <= pwdata[pf_pkg::SQ_HALF_W-1:0];
                pf_pkg::REG_SQ23:   r_sq23   <= pwdata[pf_pkg::SQ_HALF_W-1:0];
                pf_pkg::REG_SQ4:    r_sq4    <= pwdata[pf_pkg::SQ_ROW_W-1:0];
                pf_pkg::REG_FILLER: r_filler <= pwdata[pf_pkg::LW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            pf_pkg::REG_SQ01:   prdata = pf_pkg::DATA_W'(r_sq01);
            pf_pkg::REG_SQ23:   prdata = pf_pkg::DATA_W'(r_sq23);
            pf_pkg::REG_SQ4:    prdata = pf_pkg::DATA_W'(r_sq4);
            pf_pkg::REG_FILLER: prdata = pf_pkg::DATA_W'(r_filler);
        endcase
    end

    assign o_cfg.square = {r_sq4, r_sq23, r_sq01};
    assign o_cfg.filler = r_filler;

endmodule

>>> rtl/core/pf_front.sv
// input side: pairs letters up, handles doubled letters and odd endings, job register
module pf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pf_pkg::t_cfg    i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_mode,
    input  pf_pkg::t_letter i_letter,
    input  logic            i_last,
    output logic            o_job_valid,
    output pf_pkg::t_job    o_job,
    input  logic            i_job_take
);

    pf_pkg::t_letter r_held_letter;
    logic            r_held_valid;
    logic            r_job_valid;
    pf_pkg::t_job    r_job;

    pf_pkg::t_letter n_held_letter;
    logic            n_held_valid;
    logic            make_job;
    pf_pkg::t_job    new_job;
    pf_pkg::t_letter l;
    pf_pkg::t_letter fill;
    logic            accept;

    assign o_stall = r_job_valid && !i_job_take;
    assign accept  = i_valid && !o_stall;
    assign l       = pf_pkg::fold_j(i_letter);
    assign fill    = pf_pkg::fold_j(i_cfg.filler);

    always_comb begin
        n_held_letter = r_held_letter;
        n_held_valid  = r_held_valid;
        make_job      = 1'b0;
        new_job.kind  = pf_pkg::K_PAIR;
        new_job.a     = l;
        new_job.b     = fill;
        new_job.dec   = 1'b0;
        new_job.fin   = i_last;
        if (!r_held_valid) begin
            if (!i_last) begin
                n_held_letter = l;
                n_held_valid  = 1'b1;
            end else begin
                // lone last letter: pad when encrypting, odd ciphertext otherwise
                make_job = 1'b1;
                if (i_mode) begin
                    new_job.kind = pf_pkg::K_ODD;
                end
            end
        end else begin
            n_held_valid = 1'b0;
            make_job     = 1'b1;
            if (!i_mode && r_held_letter == l) begin
                if (i_last) begin
                    // both halves pair with the filler, same pair twice
                    new_job.kind = pf_pkg::K_REPEAT;
                end else begin
                    new_job.fin   = 1'b0;
                    n_held_letter = l;
                    n_held_valid  = 1'b1;
                end
            end else begin
                new_job.a     = r_held_letter;
                new_job.b     = l;
                new_job.dec   = i_mode;
                n_held_letter = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_letter <= '0;
            r_held_valid  <= 1'b0;
            r_job_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_held_letter <= n_held_letter;
                r_held_valid  <= n_held_valid;
            end
            if (accept && make_job) begin
                r_job_valid <= 1'b1;
            end else if (i_job_take) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && make_job) begin
            r_job <= new_job;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

>>> rtl/core/pf_burst.sv
// square lookup, substitution, burst buffer draining one beat per unstalled cycle
module pf_burst (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pf_pkg::t_cfg    i_cfg,
    input  logic            i_job_valid,
    input  pf_pkg::t_job    i_job,
    output logic            o_job_take,
    output logic            o_valid,
    input  logic            i_stall,
    output pf_pkg::t_letter o_letter,
    output logic            o_last,
    output logic            o_bad
);

    pf_pkg::t_beat r_slot [pf_pkg::BURST_MAX];
    logic [2:0]    r_left;
    logic [1:0]    r_pos;

    pf_pkg::t_beat n_slot [pf_pkg::BURST_MAX];
    logic [2:0]    n_cnt;
    pf_pkg::t_loc  loc_a;
    pf_pkg::t_loc  loc_b;
    pf_pkg::t_pos  ra, ca, rb, cb;
    pf_pkg::t_letter x, y;
    logic          bad;
    logic          out_take;

    assign loc_a = pf_pkg::locate(i_cfg.square, i_job.a);
    assign loc_b = pf_pkg::locate(i_cfg.square, i_job.b);
    assign bad   = !loc_a.found || !loc_b.found;

    always_comb begin
        ra = loc_a.row;
        ca = loc_a.col;
        rb = loc_b.row;
        cb = loc_b.col;
        if (loc_a.row == loc_b.row) begin
            ca = pf_pkg::wrap_step(loc_a.col, i_job.dec);
            cb = pf_pkg::wrap_step(loc_b.col, i_job.dec);
        end else if (loc_a.col == loc_b.col) begin
            ra = pf_pkg::wrap_step(loc_a.row, i_job.dec);
            rb = pf_pkg::wrap_step(loc_b.row, i_job.dec);
        end else begin
            ca = loc_b.col;
            cb = loc_a.col;
        end
    end

    assign x = i_cfg.square[ra][ca];
    assign y = i_cfg.square[rb][cb];

    always_comb begin
        for (int i = 0; i < pf_pkg::BURST_MAX; i++) begin
            n_slot[i] = '0;
        end
        n_cnt = '0;
        unique case (i_job.kind)
            pf_pkg::K_ODD: begin
                n_slot[0] = '{letter: '0, last: 1'b1, bad: 1'b1};
                n_cnt     = 3'd1;
            end
            pf_pkg::K_PAIR: begin
                if (bad) begin
                    n_slot[0] = '{letter: '0, last: i_job.fin, bad: 1'b1};
                    n_cnt     = 3'd1;
                end else if (i_job.dec && i_job.fin && y == i_cfg.filler) begin
                    // trailing filler dropped from the decrypted text
                    n_slot[0] = '{letter: x, last: 1'b1, bad: 1'b0};
                    n_cnt     = 3'd1;
                end else begin
                    n_slot[0] = '{letter: x, last: 1'b0, bad: 1'b0};
                    n_slot[1] = '{letter: y, last: i_job.fin, bad: 1'b0};
                    n_cnt     = 3'd2;
                end
            end
            pf_pkg::K_REPEAT: begin
                if (bad) begin
                    n_slot[0] = '{letter: '0, last: 1'b0, bad: 1'b1};
                    n_slot[1] = '{letter: '0, last: 1'b1, bad: 1'b1};
                    n_cnt     = 3'd2;
                end else begin
                    n_slot[0] = '{letter: x, last: 1'b0, bad: 1'b0};
                    n_slot[1] = '{letter: y, last: 1'b0, bad: 1'b0};
                    n_slot[2] = '{letter: x, last: 1'b0, bad: 1'b0};
                    n_slot[3] = '{letter: y, last: 1'b1, bad: 1'b0};
                    n_cnt     = 3'd4;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign o_valid    = (r_left != '0);
    assign out_take   = o_valid && !i_stall;
    // reload when empty or while the final beat of the current burst leaves
    assign o_job_take = i_job_valid &&
                        ((r_left == '0) || (r_left == 3'd1 && out_take));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pos  <= '0;
        end else if (o_job_take) begin
            r_left <= n_cnt;
            r_pos  <= '0;
        end else if (out_take) begin
            r_left <= r_left - 3'd1;
            r_pos  <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            for (int i = 0; i < pf_pkg::BURST_MAX; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end
    end

    assign o_letter = r_slot[r_pos].letter;
    assign o_last   = r_slot[r_pos].last;
    assign o_bad    = r_slot[r_pos].bad;

endmodule

>>> rtl/core/playfair_digraph_cipher.sv
// Playfair digraph cipher: letters in one beat at a time, substituted letters out in bursts.
// Letters arrive one per input beat and are paired in the front end; a letter that only
// opens a pair is absorbed and gives no output. A completed pair is held in one job
// register, looked up in the 5x5 square and substituted in a single pass, and loaded into
// a four-beat burst buffer, drained one beat per cycle while i_stall is low. A pair yields
// one or two result beats, four for a doubled last letter when encrypting. The input keeps
// flowing while the burst drains until a second pair waits in the job register; clean
// pairs stream at one letter per cycle if unstalled. A completed pair goes through the job
// register and then the burst buffer to the output. Software must write the square and the
// filler letter through the register port while the block is idle; it is not enforced.
module playfair_digraph_cipher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pf_pkg::ADDR_W-1:0] paddr,
    input  logic [pf_pkg::DATA_W-1:0] pwdata,
    output logic [pf_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_mode,
    input  logic [4:0]                i_letter,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [4:0]                o_out_letter,
    output logic                      o_out_last,
    output logic                      o_bad_input
);

    pf_pkg::t_cfg cfg;
    logic         job_valid;
    pf_pkg::t_job job;
    logic         job_take;

    pf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_letter    (i_letter),
        .i_last      (i_last),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take)
    );

    pf_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_letter    (o_out_letter),
        .o_last      (o_out_last),
        .o_bad       (o_bad_input)
    );

endmodule
